FILE: src/sxtok_pkg.sv
// Shared types, constants and the between-token decode function for the tokenizer.
// Used by sxtok_lexer, sxtok_out_queue and the top level; depends on nothing.
`default_nettype none
package sxtok_pkg;

  localparam int LINE_BITS    = 24;
  localparam int LINE_OUT_W   = 24;
  localparam int LINE_CMP_W   = (LINE_BITS > LINE_OUT_W) ? LINE_BITS : LINE_OUT_W;
  localparam logic [LINE_CMP_W-1:0] LINE_OUT_MAX = LINE_CMP_W'((64'd1 << LINE_OUT_W) - 64'd1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_STR_ESC = 3'd2,
    MODE_ML      = 3'd3,
    MODE_ML_ESC  = 3'd4,
    MODE_ML_NL   = 3'd5,
    MODE_ML_NLCR = 3'd6,
    MODE_ATOM    = 3'd7
  } lex_mode_t;

  typedef enum logic [2:0] {
    EV_OPEN    = 3'd0,
    EV_CLOSE   = 3'd1,
    EV_DATA    = 3'd2,
    EV_STREND  = 3'd3,
    EV_ATOMEND = 3'd4,
    EV_EOF     = 3'd5,
    EV_ERR     = 3'd6
  } event_t;

  typedef struct packed {
    event_t                  ev;
    logic [7:0]              data;
    logic [LINE_OUT_W-1:0]   line;
    logic                    last;
  } res_entry_t;

  typedef struct packed {
    logic       v0;
    logic       v1;
    res_entry_t e0;
    res_entry_t e1;
  } lex_res_t;

  typedef struct packed {
    lex_mode_t  mode;
    logic       emit;
    event_t     ev;
    logic [7:0] data;
    logic       inc;
  } idle_dec_t;

  function automatic idle_dec_t idle_byte(input logic [7:0] c);
    idle_dec_t d;
    d.mode = MODE_IDLE;
    d.emit = 1'b0;
    d.ev   = EV_DATA;
    d.data = 8'd0;
    d.inc  = 1'b0;
    unique case (c)
      CH_OPEN: begin
        d.emit = 1'b1;
        d.ev   = EV_OPEN;
      end
      CH_CLOSE: begin
        d.emit = 1'b1;
        d.ev   = EV_CLOSE;
      end
      CH_LF: d.inc = 1'b1;
      CH_SPACE, CH_CR, CH_TAB: d.mode = MODE_IDLE;
      CH_QUOTE: d.mode = MODE_STR;
      CH_BAR: d.mode = MODE_ML;
      default: begin
        d.emit = 1'b1;
        d.ev   = EV_DATA;
        d.data = c;
        d.mode = MODE_ATOM;
      end
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: src/sxtok_lexer.sv
// Lexing mode and line count registers with the per-byte decode logic.
// Produces up to two results per accepted request; depends on sxtok_pkg.
`default_nettype none
module sxtok_lexer
  import sxtok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] ch,
  input  wire logic       at_end,
  output lex_res_t        res
);

  lex_mode_t              mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic                   inc;
  logic                   v0, v1;
  event_t                 ev0, ev1;
  logic [7:0]             d0, d1;
  idle_dec_t              id;
  logic [LINE_CMP_W-1:0]  line_ext;
  logic [LINE_OUT_W-1:0]  line_out;

  always_comb begin
    mode_nxt = mode_r;
    inc      = 1'b0;
    v0       = 1'b0;
    v1       = 1'b0;
    ev0      = EV_DATA;
    ev1      = EV_DATA;
    d0       = 8'd0;
    d1       = 8'd0;
    id       = idle_byte(ch);
    if (at_end) begin
      mode_nxt = MODE_IDLE;
      v0       = 1'b1;
      unique case (mode_r)
        MODE_IDLE: ev0 = EV_EOF;
        MODE_STR, MODE_STR_ESC: ev0 = EV_ERR;
        MODE_ATOM: begin
          ev0 = EV_ATOMEND;
          v1  = 1'b1;
          ev1 = EV_EOF;
        end
        MODE_ML, MODE_ML_ESC, MODE_ML_NL, MODE_ML_NLCR: begin
          ev0 = EV_STREND;
          v1  = 1'b1;
          ev1 = EV_EOF;
        end
      endcase
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          mode_nxt = id.mode;
          inc      = id.inc;
          v0       = id.emit;
          ev0      = id.ev;
          d0       = id.data;
        end
        MODE_STR: begin
          if (ch == CH_QUOTE) begin
            v0       = 1'b1;
            ev0      = EV_STREND;
            mode_nxt = MODE_IDLE;
          end else if (ch == CH_BSL) begin
            mode_nxt = MODE_STR_ESC;
          end else begin
            v0  = 1'b1;
            ev0 = EV_DATA;
            d0  = ch;
          end
        end
        MODE_STR_ESC: begin
          v0       = 1'b1;
          ev0      = EV_DATA;
          d0       = ch;
          mode_nxt = MODE_STR;
        end
        MODE_ML: begin
          if (ch == CH_LF) begin
            inc      = 1'b1;
            mode_nxt = MODE_ML_NL;
          end else if (ch == CH_CR) begin
            mode_nxt = MODE_ML;
          end else if (ch == CH_BSL) begin
            mode_nxt = MODE_ML_ESC;
          end else begin
            v0  = 1'b1;
            ev0 = EV_DATA;
            d0  = ch;
          end
        end
        MODE_ML_ESC: begin
          v0       = 1'b1;
          ev0      = EV_DATA;
          d0       = ch;
          mode_nxt = MODE_ML;
        end
        MODE_ML_NL, MODE_ML_NLCR: begin
          if ((ch == CH_CR) && (mode_r == MODE_ML_NL)) begin
            mode_nxt = MODE_ML_NLCR;
          end else if (ch == CH_BAR) begin
            v0       = 1'b1;
            ev0      = EV_DATA;
            d0       = CH_LF;
            mode_nxt = MODE_ML;
          end else begin
            v0       = 1'b1;
            ev0      = EV_STREND;
            mode_nxt = id.mode;
            inc      = id.inc;
            v1       = id.emit;
            ev1      = id.ev;
            d1       = id.data;
          end
        end
        MODE_ATOM: begin
          if ((ch == CH_OPEN) || (ch == CH_CLOSE) || (ch == CH_QUOTE) || (ch == CH_LF)) begin
            v0       = 1'b1;
            ev0      = EV_ATOMEND;
            mode_nxt = id.mode;
            inc      = id.inc;
            v1       = id.emit;
            ev1      = id.ev;
            d1       = id.data;
          end else if ((ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_TAB)) begin
            v0       = 1'b1;
            ev0      = EV_ATOMEND;
            mode_nxt = MODE_IDLE;
          end else begin
            v0  = 1'b1;
            ev0 = EV_DATA;
            d0  = ch;
          end
        end
      endcase
    end
  end

  always_comb begin
    line_nxt = line_r;
    if (inc && (line_r != {LINE_BITS{1'b1}})) begin
      line_nxt = line_r + LINE_BITS'(1);
    end
    line_ext = LINE_CMP_W'(line_nxt);
    if (line_ext > LINE_OUT_MAX) begin
      line_out = LINE_OUT_MAX[LINE_OUT_W-1:0];
    end else begin
      line_out = line_ext[LINE_OUT_W-1:0];
    end
  end

  always_comb begin
    res.v0      = step && (v0 || v1);
    res.v1      = step && v0 && v1;
    res.e0.ev   = v0 ? ev0 : ev1;
    res.e0.data = v0 ? d0 : d1;
    res.e0.line = line_out;
    res.e0.last = !(v0 && v1);
    res.e1.ev   = ev1;
    res.e1.data = d1;
    res.e1.line = line_out;
    res.e1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      line_r <= LINE_BITS'(1);
    end else if (step) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/sxtok_out_queue.sv
// Small result queue that takes one or two results per cycle and hands out one.
// Decouples the lexer from output stalls; depends on sxtok_pkg.
`default_nettype none
module sxtok_out_queue
  import sxtok_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire lex_res_t wr,
  output logic          room2,
  output logic          rd_valid,
  input  wire logic     rd_ready,
  output res_entry_t    rd_data
);

  res_entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    pop;
  logic [QCNT_W-1:0]       n_push;

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign room2    = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop      = rd_valid && rd_ready;
  assign n_push   = QCNT_W'(wr.v0) + QCNT_W'(wr.v1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + n_push - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr.v0) begin
      mem_r[wr_ptr_r] <= wr.e0;
    end
    if (wr.v1) begin
      mem_r[wr_ptr_r + QPTR_W'(1)] <= wr.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/sexpr_model_file_tokenizer_top.sv
// Top level of the parenthesised model-file tokenizer: stream ports around the lexer.
// Instantiates sxtok_lexer and sxtok_out_queue; depends on sxtok_pkg.
//
// The tokenizer accepts one text byte (or an end-of-file mark) per cycle while its
// input is ready and produces zero, one or two events for it, which are registered
// in the result queue before they appear on the output. The input is ready whenever
// the four-entry result queue has room for two results, so a stream of bytes that
// each give at most one event runs at one byte per cycle while the output is ready;
// bytes that give two events (a parenthesis that ends an atom, a byte that ends a
// multi-line string and starts a token, end of file in an atom or multi-line
// string) put two events in the queue, and the output port sets the sustained
// rate then. All events of one byte carry the same line number; the last has tlast set.
`default_nettype none
module sexpr_model_file_tokenizer_top
  import sxtok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tuser,   // [0] at_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] data, [31:8] line
  output logic [2:0]       out_tuser,  // [2:0] event_res
  output logic             out_tlast
);

  lex_res_t   lex_res;
  res_entry_t head;
  logic       room2;
  logic       step;

  assign in_tready = room2;
  assign step      = in_tvalid && room2;

  sxtok_lexer u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .ch     (in_tdata),
    .at_end (in_tuser),
    .res    (lex_res)
  );

  sxtok_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (lex_res),
    .room2    (room2),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {head.line, head.data};
  assign out_tuser = head.ev;
  assign out_tlast = head.last;

endmodule
`default_nettype wire
